FILE: rtl/core/gf251_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf251_pkg
// Types, constants and helper functions shared by the GF(2^251) multiplier.
// ----------------------------------------------------------------------------
package gf251_pkg;

  // Operand and result geometry.
  localparam int LIMB_W    = 64;
  localparam int OPND_W    = 4 * LIMB_W;
  localparam int FIELD_DEG = 251;
  localparam int TOP_BITS  = FIELD_DEG - 3 * LIMB_W;

  // Slicing of the operands for the partial products.
  localparam int SLICE_W = 32;
  localparam int NSLICE  = OPND_W / SLICE_W;
  localparam int NPP     = NSLICE * NSLICE;
  localparam int PP_W    = 2 * SLICE_W - 1;

  // Full carry-less product width.
  localparam int PROD_W = 2 * OPND_W - 1;
  localparam int HI_W   = PROD_W - OPND_W;

  // Fold constant: x^256 = x^5 * (x^7 + x^4 + x^2 + 1).
  localparam int              FOLD_W     = 13;
  localparam logic [FOLD_W-1:0] FOLD_CONST = 13'h12a0;
  localparam int              ACC_W      = OPND_W + FOLD_W - 1;

  // Final reduction constant: x^7 + x^4 + x^2 + 1.
  localparam int             RED_CW    = 8;
  localparam logic [RED_CW-1:0] RED_CONST = 8'h95;
  localparam int             TOP_W     = ACC_W - FIELD_DEG;
  localparam int             RED_W     = TOP_W + RED_CW - 1;

  typedef struct packed {
    logic [LIMB_W-1:0] a_limb0;
    logic [LIMB_W-1:0] a_limb1;
    logic [LIMB_W-1:0] a_limb2;
    logic [LIMB_W-1:0] a_limb3;
    logic [LIMB_W-1:0] b_limb0;
    logic [LIMB_W-1:0] b_limb1;
    logic [LIMB_W-1:0] b_limb2;
    logic [LIMB_W-1:0] b_limb3;
  } in_req_t;

  typedef struct packed {
    logic [LIMB_W-1:0]   product_limb0;
    logic [LIMB_W-1:0]   product_limb1;
    logic [LIMB_W-1:0]   product_limb2;
    logic [TOP_BITS-1:0] product_limb3;
  } out_req_t;

  typedef logic [NPP-1:0][PP_W-1:0] pp_arr_t;

  // Carry-less product of two 32-bit slices.
  function automatic logic [PP_W-1:0] clmul_slice(input logic [SLICE_W-1:0] a,
                                                  input logic [SLICE_W-1:0] b);
    logic [PP_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < SLICE_W; i++) begin
      if (b[i]) begin
        acc[i +: SLICE_W] = acc[i +: SLICE_W] ^ a;
      end
    end
    return acc;
  endfunction

endpackage

FILE: rtl/core/gf2_251_field_multiplier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_251_field_multiplier_unit
// Pipelined multiplier in GF(2^251) modulo x^251 + x^7 + x^4 + x^2 + 1.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries two 256-bit binary polynomials as
//   four 64-bit limbs each; operands need not be reduced. The out_ channel
//   returns one fully reduced 251-bit product per request, in order.
//   Both channels use valid/ready; a request moves on when both are high.
//   Each accepted request passes through four pipeline registers before
//   out_valid: partial products, product summation, high-half fold, final
//   reduction into the output register. One request can be accepted every
//   cycle unless every stage is full.
//   When the receiver holds out_ready low, the pipeline fills up and
//   in_ready drops once every stage holds a request; nothing is lost or
//   repeated. Synchronous reset empties the pipeline but not the data regs.
// ----------------------------------------------------------------------------
module gf2_251_field_multiplier_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gf251_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output gf251_pkg::out_req_t out_req
);
  import gf251_pkg::*;

  pp_arr_t           pp_w;
  logic [PROD_W-1:0] prod_w;
  logic [ACC_W-1:0]  acc_w;
  logic              pp_valid;
  logic              pp_ready;
  logic              sum_valid;
  logic              sum_ready;
  logic              fold_valid;
  logic              fold_ready;

  // Stage 1: partial products.
  gf251_pp_stage u_pp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_req   (in_req),
    .dn_valid (pp_valid),
    .dn_ready (pp_ready),
    .dn_pp    (pp_w)
  );

  // Stage 2: full carry-less product.
  gf251_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pp_valid),
    .up_ready (pp_ready),
    .up_pp    (pp_w),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_prod  (prod_w)
  );

  // Stage 3: fold of the high half.
  gf251_fold_stage u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_prod  (prod_w),
    .dn_valid (fold_valid),
    .dn_ready (fold_ready),
    .dn_acc   (acc_w)
  );

  // Stage 4: final reduction and output register.
  gf251_red_stage u_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fold_valid),
    .up_ready (fold_ready),
    .up_acc   (acc_w),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_req   (out_req)
  );

endmodule

FILE: rtl/core/gf251_pp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf251_pp_stage
// First pipeline stage: all 32x32 carry-less partial products of the operands.
// ----------------------------------------------------------------------------
module gf251_pp_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  gf251_pkg::in_req_t up_req,
  output logic              dn_valid,
  input  logic              dn_ready,
  output gf251_pkg::pp_arr_t dn_pp
);
  import gf251_pkg::*;

  logic [OPND_W-1:0] opnd_a;
  logic [OPND_W-1:0] opnd_b;
  pp_arr_t           pp_nxt;
  pp_arr_t           pp_r;
  logic              valid_r;

  assign opnd_a = {up_req.a_limb3, up_req.a_limb2, up_req.a_limb1, up_req.a_limb0};
  assign opnd_b = {up_req.b_limb3, up_req.b_limb2, up_req.b_limb1, up_req.b_limb0};

  // One independent partial product per pair of slices.
  always_comb begin
    for (int i = 0; i < NSLICE; i++) begin
      for (int j = 0; j < NSLICE; j++) begin
        pp_nxt[i*NSLICE + j] = clmul_slice(opnd_a[i*SLICE_W +: SLICE_W],
                                           opnd_b[j*SLICE_W +: SLICE_W]);
      end
    end
  end

  // The stage moves on when it is empty or its content is taken.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pp_r <= pp_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pp    = pp_r;

endmodule

FILE: rtl/core/gf251_sum_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf251_sum_stage
// Second pipeline stage: XOR of the shifted partial products into the full
// 511-bit carry-less product.
// ----------------------------------------------------------------------------
module gf251_sum_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  gf251_pkg::pp_arr_t        up_pp,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [gf251_pkg::PROD_W-1:0] dn_prod
);
  import gf251_pkg::*;

  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              valid_r;

  // Each partial product lands at the sum of its two slice offsets.
  always_comb begin
    prod_nxt = '0;
    for (int i = 0; i < NSLICE; i++) begin
      for (int j = 0; j < NSLICE; j++) begin
        prod_nxt[SLICE_W*(i+j) +: PP_W] = prod_nxt[SLICE_W*(i+j) +: PP_W]
                                          ^ up_pp[i*NSLICE + j];
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_prod  = prod_r;

endmodule

FILE: rtl/core/gf251_fold_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf251_fold_stage
// Third pipeline stage: folds product bits 256 and above back down using
// x^256 = x^5 * (x^7 + x^4 + x^2 + 1).
// ----------------------------------------------------------------------------
module gf251_fold_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [gf251_pkg::PROD_W-1:0] up_prod,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [gf251_pkg::ACC_W-1:0]  dn_acc
);
  import gf251_pkg::*;

  logic [HI_W-1:0]  prod_hi;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] acc_r;
  logic             valid_r;

  assign prod_hi = up_prod[PROD_W-1:OPND_W];

  // Low half plus the high half times the fold constant.
  always_comb begin
    acc_nxt = {{(ACC_W-OPND_W){1'b0}}, up_prod[OPND_W-1:0]};
    for (int s = 0; s < FOLD_W; s++) begin
      if (FOLD_CONST[s]) begin
        acc_nxt[s +: HI_W] = acc_nxt[s +: HI_W] ^ prod_hi;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_acc   = acc_r;

endmodule

FILE: rtl/core/gf251_red_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf251_red_stage
// Last pipeline stage: removes bits 251 and above with x^251 = x^7+x^4+x^2+1
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module gf251_red_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [gf251_pkg::ACC_W-1:0] up_acc,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output gf251_pkg::out_req_t         dn_req
);
  import gf251_pkg::*;

  logic [TOP_W-1:0]     top_bits;
  logic [RED_W-1:0]     red_val;
  logic [FIELD_DEG-1:0] res_nxt;
  out_req_t             req_nxt;
  out_req_t             req_r;
  logic                 valid_r;

  assign top_bits = up_acc[ACC_W-1:FIELD_DEG];

  // Top bits times the reduction polynomial, folded into the low end.
  always_comb begin
    red_val = '0;
    for (int s = 0; s < RED_CW; s++) begin
      if (RED_CONST[s]) begin
        red_val[s +: TOP_W] = red_val[s +: TOP_W] ^ top_bits;
      end
    end
    res_nxt = up_acc[FIELD_DEG-1:0] ^ {{(FIELD_DEG-RED_W){1'b0}}, red_val};
  end

  always_comb begin
    req_nxt.product_limb0 = res_nxt[0*LIMB_W +: LIMB_W];
    req_nxt.product_limb1 = res_nxt[1*LIMB_W +: LIMB_W];
    req_nxt.product_limb2 = res_nxt[2*LIMB_W +: LIMB_W];
    req_nxt.product_limb3 = res_nxt[3*LIMB_W +: TOP_BITS];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      req_r <= req_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_req   = req_r;

endmodule
